>>> rtl/core/tsolp_pkg.sv
// ----------------------------------------------------------------------------
// tsolp_pkg
// Types, constants and helpers for the three-axis second-order low-pass core.
// ----------------------------------------------------------------------------
`default_nettype none

package tsolp_pkg;

	localparam int AXES      = 3;
	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 19;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = COEF_W + SAMPLE_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int SHIFT_W   = ACC_W - FRAC_BITS;
	localparam int CFG_IDX_W = 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [SHIFT_W-1:0]  shifted_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	localparam cfg_idx_t REG_FEED   = 2'd0;
	localparam cfg_idx_t REG_FIRST  = 2'd1;
	localparam cfg_idx_t REG_SECOND = 2'd2;

	localparam coef_t FEED_RESET   = 19'sd12345;
	localparam coef_t FIRST_RESET  = 19'sd67089;
	localparam coef_t SECOND_RESET = 19'sd13897;

	localparam shifted_t SAT_MAX = shifted_t'(32767);
	localparam shifted_t SAT_MIN = -shifted_t'(32768);

	function automatic sample_t saturate(input shifted_t v);
		sample_t r;
		if (v > SAT_MAX) begin
			r = sample_t'(SAT_MAX);
		end else if (v < SAT_MIN) begin
			r = sample_t'(SAT_MIN);
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/three_axis_second_order_lowpass_core.sv
// ----------------------------------------------------------------------------
// three_axis_second_order_lowpass_core
// Per-axis all-pole low-pass y = b0*x + a1*y1 - a2*y2 on x, y and z samples.
// Coefficients are signed Q2.16; each sum is floor-shifted by 16 and
// saturated to 16 bits, and the saturated value enters the axis history.
// One sample transfer is accepted every cycle while the output side keeps up:
// a sample lands in an input register, then a multiply-add per axis (three
// 19x16 multipliers per axis) writes the result register and the history
// together; the output is taken from the result register. The user must
// write coefficients through the cfg port only while the core is idle; the
// core itself does not enforce this. A write to index 3 is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_second_order_lowpass_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [tsolp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [tsolp_pkg::COEF_W-1:0]    cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [tsolp_pkg::SAMPLE_W-1:0]  sample_x,
	input  wire  [tsolp_pkg::SAMPLE_W-1:0]  sample_y,
	input  wire  [tsolp_pkg::SAMPLE_W-1:0]  sample_z,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [tsolp_pkg::SAMPLE_W-1:0]  filtered_x,
	output logic [tsolp_pkg::SAMPLE_W-1:0]  filtered_y,
	output logic [tsolp_pkg::SAMPLE_W-1:0]  filtered_z
);

	tsolp_pkg::coef_t   feed_q;
	tsolp_pkg::coef_t   first_q;
	tsolp_pkg::coef_t   second_q;

	logic               valid_s1;
	tsolp_pkg::sample_t samp_s1  [tsolp_pkg::AXES];
	tsolp_pkg::sample_t last_q   [tsolp_pkg::AXES];
	tsolp_pkg::sample_t older_q  [tsolp_pkg::AXES];
	tsolp_pkg::sample_t result_q [tsolp_pkg::AXES];
	logic               out_valid_q;

	tsolp_pkg::prod_t    prod_b   [tsolp_pkg::AXES];
	tsolp_pkg::prod_t    prod_a1  [tsolp_pkg::AXES];
	tsolp_pkg::prod_t    prod_a2  [tsolp_pkg::AXES];
	tsolp_pkg::acc_t     acc      [tsolp_pkg::AXES];
	tsolp_pkg::shifted_t shifted  [tsolp_pkg::AXES];
	tsolp_pkg::sample_t  y_new    [tsolp_pkg::AXES];

	logic advance;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_q   <= tsolp_pkg::FEED_RESET;
			first_q  <= tsolp_pkg::FIRST_RESET;
			second_q <= tsolp_pkg::SECOND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsolp_pkg::REG_FEED:   feed_q   <= cfg_data;
				tsolp_pkg::REG_FIRST:  first_q  <= cfg_data;
				tsolp_pkg::REG_SECOND: second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			samp_s1[0] <= sample_x;
			samp_s1[1] <= sample_y;
			samp_s1[2] <= sample_z;
		end
	end

	// per-axis multiply-add, floor shift and saturation
	always_comb begin
		for (int a = 0; a < tsolp_pkg::AXES; a++) begin
			prod_b[a]  = tsolp_pkg::prod_t'(feed_q) * tsolp_pkg::prod_t'(samp_s1[a]);
			prod_a1[a] = tsolp_pkg::prod_t'(first_q) * tsolp_pkg::prod_t'(last_q[a]);
			prod_a2[a] = tsolp_pkg::prod_t'(second_q) * tsolp_pkg::prod_t'(older_q[a]);
			acc[a]     = tsolp_pkg::acc_t'(prod_b[a]) + tsolp_pkg::acc_t'(prod_a1[a])
				- tsolp_pkg::acc_t'(prod_a2[a]);
			shifted[a] = acc[a][tsolp_pkg::ACC_W-1:tsolp_pkg::FRAC_BITS];
			y_new[a]   = tsolp_pkg::saturate(shifted[a]);
		end
	end

	// history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < tsolp_pkg::AXES; a++) begin
				last_q[a]  <= '0;
				older_q[a] <= '0;
			end
		end else if (advance) begin
			for (int a = 0; a < tsolp_pkg::AXES; a++) begin
				older_q[a] <= last_q[a];
				last_q[a]  <= y_new[a];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int a = 0; a < tsolp_pkg::AXES; a++) begin
				result_q[a] <= y_new[a];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign filtered_x = result_q[0];
	assign filtered_y = result_q[1];
	assign filtered_z = result_q[2];

`ifndef SYNTHESIS
	// a held result always matches the newest history entry
	a_result_is_history: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q[0] == last_q[0]) && (result_q[1] == last_q[1])
			&& (result_q[2] == last_q[2]))
		else $error("result register and history disagree");

	// history shifts by one on every advance
	a_history_shift: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (older_q[0] == $past(last_q[0])) && (older_q[1] == $past(last_q[1]))
			&& (older_q[2] == $past(last_q[2])))
		else $error("history did not shift");

	// an input transfer always fills the input register
	a_transfer_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("input transfer lost");

	// an advance always produces a pending result
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advance did not produce a result");
`endif

endmodule

`default_nettype wire
